FILE: rtl/core/lppd_pkg.sv
package lppd_pkg;

  localparam int MAX_EXPONENT = 8;
  localparam int EXP_W        = $clog2(MAX_EXPONENT + 1);

  localparam int YEAR_W  = 12;
  localparam int LAG_W   = 8;
  localparam int DUR_W   = 8;
  localparam int PEAK_W  = 16;
  localparam int CFGX_W  = 4;
  localparam int LEND_W  = YEAR_W + 1;
  localparam int PEND_W  = YEAR_W + 2;
  localparam int BASE_W  = YEAR_W + 1;
  localparam int POW_W   = PEAK_W + 1;
  localparam int PROD_W  = POW_W + BASE_W;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_DATA_W  = 12;

  localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};
  localparam logic [POW_W-1:0]  POW_SAT  = {1'b1, {PEAK_W{1'b0}}};

  typedef enum logic [0:0] {
    CFG_CURRENT_YEAR = 1'b0,
    CFG_DECAY_EXP    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PEAK_W-1:0] dividend;
    logic [BASE_W-1:0] base;
    logic [POW_W-1:0]  power;
    logic [EXP_W-1:0]  exp_left;
  } pow_beat_t;

  typedef struct packed {
    logic [POW_W-1:0]  divisor;
    logic [POW_W-1:0]  rem;
    logic [PEAK_W-1:0] quo;
  } div_beat_t;

endpackage

FILE: rtl/core/lppd_pow_cell.sv
module lppd_pow_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  lppd_pkg::pow_beat_t in_beat,
  output logic                out_valid,
  output lppd_pkg::pow_beat_t out_beat
);

  logic                      valid_r;
  lppd_pkg::pow_beat_t       beat_r;
  lppd_pkg::pow_beat_t       beat_nxt;
  logic [lppd_pkg::PROD_W-1:0] prod;

  always_comb begin
    prod     = lppd_pkg::PROD_W'(in_beat.power) * lppd_pkg::PROD_W'(in_beat.base);
    beat_nxt = in_beat;
    if (in_beat.exp_left != '0) begin
      beat_nxt.exp_left = in_beat.exp_left - 1'b1;
      if (prod > lppd_pkg::PROD_W'(lppd_pkg::PEAK_MAX)) begin
        beat_nxt.power = lppd_pkg::POW_SAT;
      end else begin
        beat_nxt.power = lppd_pkg::POW_W'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
    if (adv) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  a_pow_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (beat_r.power != '0 && beat_r.power <= lppd_pkg::POW_SAT))
    else $error("power left its saturating range");

endmodule

FILE: rtl/core/lppd_div_cell.sv
module lppd_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  lppd_pkg::div_beat_t in_beat,
  output logic                out_valid,
  output lppd_pkg::div_beat_t out_beat
);

  logic                        valid_r;
  lppd_pkg::div_beat_t         beat_r;
  lppd_pkg::div_beat_t         beat_nxt;
  logic [lppd_pkg::POW_W:0]    shifted;
  logic [lppd_pkg::POW_W:0]    dvs;
  logic                        ge;

  // one restoring step: one quotient bit per cell, MSB first
  always_comb begin
    shifted  = {in_beat.rem, in_beat.quo[lppd_pkg::PEAK_W-1]};
    dvs      = {1'b0, in_beat.divisor};
    ge       = (shifted >= dvs);
    beat_nxt = in_beat;
    beat_nxt.quo = {in_beat.quo[lppd_pkg::PEAK_W-2:0], ge};
    if (ge) begin
      beat_nxt.rem = lppd_pkg::POW_W'(shifted - dvs);
    end else begin
      beat_nxt.rem = lppd_pkg::POW_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
    if (adv) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (beat_r.rem < beat_r.divisor))
    else $error("partial remainder not below divisor");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (beat_r.divisor != '0))
    else $error("zero divisor in division chain");

endmodule

FILE: rtl/core/lagged_peak_power_decay_top.sv
// Node fitness at the configured current year: 1 during the lag, the peak level through the
// end of the peak window, then floor(peak_level / (years past peak + 1)^decay_exponent), with
// the exponent clamped to MAX_EXPONENT and 0 once the power exceeds the peak level. One beat is
// accepted per cycle; each result passes through an entry register, one multiply cell per
// exponent step and one restoring-division cell per quotient bit. The whole chain holds while
// the result register is stalled. Write configuration only while the chain is empty.
module lagged_peak_power_decay_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // publish_year[11:0], lag_years[19:12], peak_years[27:20], peak_level[43:28]
  input  logic [lppd_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // fitness_value[15:0]
  output logic [lppd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_wr_en,
  input  lppd_pkg::cfg_reg_t                   cfg_addr,
  input  logic [lppd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int NPOW = lppd_pkg::MAX_EXPONENT;
  localparam int NDIV = lppd_pkg::PEAK_W;

  logic [lppd_pkg::YEAR_W-1:0] cur_year_r;
  logic [lppd_pkg::CFGX_W-1:0] decay_exp_r;

  logic adv;

  logic [lppd_pkg::YEAR_W-1:0] pub;
  logic [lppd_pkg::LAG_W-1:0]  lag;
  logic [lppd_pkg::DUR_W-1:0]  dur;
  logic [lppd_pkg::PEAK_W-1:0] peak;
  logic [lppd_pkg::LEND_W-1:0] lag_end;
  logic [lppd_pkg::PEND_W-1:0] peak_end;
  logic                        in_lag;
  logic                        in_peak;
  logic [lppd_pkg::EXP_W-1:0]  exp_cl;

  lppd_pkg::pow_beat_t entry_nxt;
  logic                entry_v_r;
  lppd_pkg::pow_beat_t entry_r;

  logic                pow_v [NPOW+1];
  lppd_pkg::pow_beat_t pow_b [NPOW+1];
  logic                div_v [NDIV+1];
  lppd_pkg::div_beat_t div_b [NDIV+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_year_r  <= '0;
      decay_exp_r <= lppd_pkg::CFGX_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        lppd_pkg::CFG_CURRENT_YEAR: cur_year_r  <= cfg_wdata;
        lppd_pkg::CFG_DECAY_EXP:    decay_exp_r <= cfg_wdata[lppd_pkg::CFGX_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_comb begin
    pub      = in_tdata[11:0];
    lag      = in_tdata[19:12];
    dur      = in_tdata[27:20];
    peak     = in_tdata[43:28];
    lag_end  = lppd_pkg::LEND_W'(pub) + lppd_pkg::LEND_W'(lag);
    peak_end = lppd_pkg::PEND_W'(lag_end) + lppd_pkg::PEND_W'(dur);
    in_lag   = lag_end > lppd_pkg::LEND_W'(cur_year_r);
    in_peak  = peak_end >= lppd_pkg::PEND_W'(cur_year_r);
    if (32'(decay_exp_r) > lppd_pkg::MAX_EXPONENT) begin
      exp_cl = lppd_pkg::EXP_W'(lppd_pkg::MAX_EXPONENT);
    end else begin
      exp_cl = lppd_pkg::EXP_W'(decay_exp_r);
    end
    // lag and peak phases run through the chain with power 1: quotient = dividend
    entry_nxt.dividend = in_lag ? lppd_pkg::PEAK_W'(1) : peak;
    entry_nxt.base     = lppd_pkg::BASE_W'(cur_year_r) - lppd_pkg::BASE_W'(peak_end)
                         + lppd_pkg::BASE_W'(1);
    entry_nxt.power    = lppd_pkg::POW_W'(1);
    entry_nxt.exp_left = (in_lag || in_peak) ? '0 : exp_cl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_v_r <= 1'b0;
    end else if (adv) begin
      entry_v_r <= in_tvalid;
    end
    if (adv) begin
      entry_r <= entry_nxt;
    end
  end

  assign pow_v[0] = entry_v_r;
  assign pow_b[0] = entry_r;

  for (genvar i = 0; i < NPOW; i++) begin : g_pow
    lppd_pow_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (pow_v[i]),
      .in_beat   (pow_b[i]),
      .out_valid (pow_v[i+1]),
      .out_beat  (pow_b[i+1])
    );
  end

  assign div_v[0]         = pow_v[NPOW];
  assign div_b[0].divisor = pow_b[NPOW].power;
  assign div_b[0].rem     = '0;
  assign div_b[0].quo     = pow_b[NPOW].dividend;

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    lppd_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (div_v[i]),
      .in_beat   (div_b[i]),
      .out_valid (div_v[i+1]),
      .out_beat  (div_b[i+1])
    );
  end

  assign out_tvalid = div_v[NDIV];
  assign out_tdata  = div_b[NDIV].quo;

  a_decay_base: assert property (@(posedge clk) disable iff (!rst_n)
    (entry_v_r && entry_r.exp_left != '0) |-> (entry_r.base >= lppd_pkg::BASE_W'(2)))
    else $error("decay base below two");

  a_exp_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    entry_v_r |-> (32'(entry_r.exp_left) <= lppd_pkg::MAX_EXPONENT))
    else $error("exponent beyond clamp");

endmodule
